// File: rtl/sdspi_pkg.sv
// ============================================================================
// sdspi_pkg: shared types, codes and the CRC7 helper for the SD SPI engine
// Holds phase, item mode and result kind codes plus the frame constants.
// ============================================================================
package sdspi_pkg;

    localparam int unsigned MAX_RESPONSE_BYTES_DEF = 5;

    // Result buffer: one command frame is the longest run of results
    localparam int unsigned RUN_DEPTH = 6;
    localparam int unsigned RUN_W     = $clog2(RUN_DEPTH + 1);

    localparam logic [6:0] CRC7_POLY   = 7'h09;   // x^7 + x^3 + 1, top bit implied
    localparam logic [7:0] CMD_START   = 8'h40;
    localparam logic [7:0] BYTE_IDLE   = 8'hFF;
    localparam logic       STAT_OK      = 1'b0;
    localparam logic       STAT_TIMEOUT = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_WAIT    = 3'd1,
        PH_CAPTURE = 3'd2,
        PH_TRAIL   = 3'd3,
        PH_BUSY    = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        MODE_START = 2'd0,
        MODE_BYTE  = 2'd1,
        MODE_TICK  = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        KIND_TX     = 2'd0,
        KIND_RESP   = 2'd1,
        KIND_STATUS = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] value;
        logic [2:0] slot;
        logic       status;
    } t_result;

    // Shift one byte MSB first through the CRC7 register
    function automatic logic [6:0] crc7_byte(input logic [6:0] crc_in,
                                             input logic [7:0] data);
        logic [6:0] c;
        logic       fb;
        c = crc_in;
        for (int b = 7; b >= 0; b--) begin
            fb = c[6] ^ data[b];
            c  = {c[5:0], 1'b0};
            if (fb) begin
                c = c ^ CRC7_POLY;
            end
        end
        return c;
    endfunction

endpackage

// File: rtl/sd_spi_command_engine_unit.sv
// ============================================================================
// sd_spi_command_engine_unit: host-side SD SPI-mode command engine
// Builds the six-byte command frame with CRC7, captures the response bytes,
// handles R1b busy wait and the first-byte timeout.
// ============================================================================
// The first result of an item is shown in the cycle after its input transfer.
// Flow: an item is taken only while the result buffer is empty or its last result
//   leaves; a start item yields six results and holds the input side until all
//   six leave; the single result buffer serializes one result per cycle while i_out_ready is high.
// Reset: synchronous, active low; engine idle, timeout register all ones,
//   result buffer empty.
module sd_spi_command_engine_unit
    import sdspi_pkg::*;
#(
    parameter int unsigned MAX_RESPONSE_BYTES = MAX_RESPONSE_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: response timeout in ticks
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    // input item channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_mode,
    input  logic [5:0]  i_command_index,
    input  logic [31:0] i_command_argument,
    input  logic [2:0]  i_response_length,
    input  logic        i_busy_wait,
    input  logic [7:0]  i_card_byte,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_result_kind,
    output logic [7:0]  o_byte_value,
    output logic [2:0]  o_response_slot,
    output logic        o_completion_status,
    output logic        o_last_of_run
);

    // ------------------------------------------------------------------------
    // Engine state
    // ------------------------------------------------------------------------
    logic [31:0] r_timeout;
    t_phase      r_phase,   n_phase;
    logic [31:0] r_elapsed, n_elapsed;
    logic [2:0]  r_left,    n_left;      // response bytes still to capture
    logic [2:0]  r_slot,    n_slot;      // slot of the next captured byte
    logic        r_busy_req, n_busy_req;

    // Result buffer: a whole run of results is loaded at once, then shown
    // one entry per cycle while i_out_ready is high.
    t_result     r_run [RUN_DEPTH];
    t_result     n_run [RUN_DEPTH];
    logic [RUN_W-1:0] r_cnt, n_cnt;      // results in the loaded run
    logic [RUN_W-1:0] r_rd;              // entry currently shown

    logic        in_xfer;
    logic        out_xfer;
    logic        run_last;
    logic        run_drain;

    // ------------------------------------------------------------------------
    // Frame build: index byte, argument MSB first, CRC7 with end bit
    // ------------------------------------------------------------------------
    logic [7:0]  frame [RUN_DEPTH];
    logic [6:0]  crc_c1, crc_c2, crc_c3, crc_c4, crc_c5;
    logic [2:0]  len_sat;
    logic [31:0] tick_sum;
    logic        timed_out;

    assign frame[0] = CMD_START | {2'b00, i_command_index};
    assign frame[1] = i_command_argument[31:24];
    assign frame[2] = i_command_argument[23:16];
    assign frame[3] = i_command_argument[15:8];
    assign frame[4] = i_command_argument[7:0];
    assign crc_c1   = crc7_byte(7'd0,   frame[0]);
    assign crc_c2   = crc7_byte(crc_c1, frame[1]);
    assign crc_c3   = crc7_byte(crc_c2, frame[2]);
    assign crc_c4   = crc7_byte(crc_c3, frame[3]);
    assign crc_c5   = crc7_byte(crc_c4, frame[4]);
    assign frame[5] = {crc_c5, 1'b1};

    // Clamp the requested length to the capture capacity
    assign len_sat = ({1'b0, i_response_length} > 4'(MAX_RESPONSE_BYTES))
                   ? 3'(MAX_RESPONSE_BYTES) : i_response_length;

    // Tick count saturates; timeout hits at or beyond the register value
    assign tick_sum  = (r_elapsed == '1) ? r_elapsed : r_elapsed + 32'd1;
    assign timed_out = (tick_sum >= r_timeout);

    // ------------------------------------------------------------------------
    // Handshakes: take a new item whenever the buffer is empty or its last
    // result leaves in this cycle.
    // ------------------------------------------------------------------------
    assign o_out_valid = (r_cnt != '0);
    assign run_last    = (r_rd == r_cnt - RUN_W'(1));
    assign out_xfer    = o_out_valid && i_out_ready;
    assign run_drain   = out_xfer && run_last;
    assign o_in_ready  = (r_cnt == '0) || run_drain;
    assign in_xfer     = i_in_valid && o_in_ready;

    // ------------------------------------------------------------------------
    // Next-state logic
    // ------------------------------------------------------------------------
    always_comb begin
        n_phase    = r_phase;
        n_elapsed  = r_elapsed;
        n_left     = r_left;
        n_slot     = r_slot;
        n_busy_req = r_busy_req;
        case (t_mode'(i_mode))
            MODE_START: begin
                // a start abandons any command in progress
                n_phase    = PH_WAIT;
                n_elapsed  = '0;
                n_left     = len_sat;
                n_slot     = '0;
                n_busy_req = i_busy_wait;
            end
            MODE_BYTE: begin
                case (r_phase)
                    PH_WAIT: begin
                        if (!i_card_byte[7]) begin
                            if (r_left == '0) begin
                                n_phase = r_busy_req ? PH_BUSY : PH_IDLE;
                            end else begin
                                n_slot  = 3'd1;
                                n_left  = r_left - 3'd1;
                                n_phase = (r_left == 3'd1) ? PH_TRAIL : PH_CAPTURE;
                            end
                        end
                    end
                    PH_CAPTURE: begin
                        n_slot = r_slot + 3'd1;
                        if (r_left != '0) begin
                            n_left = r_left - 3'd1;
                        end
                        if (r_left <= 3'd1) begin
                            n_phase = PH_TRAIL;
                        end
                    end
                    PH_TRAIL: begin
                        n_phase = r_busy_req ? PH_BUSY : PH_IDLE;
                    end
                    PH_BUSY: begin
                        if (i_card_byte == BYTE_IDLE) begin
                            n_phase = PH_IDLE;
                        end
                    end
                    default: ;
                endcase
            end
            MODE_TICK: begin
                if (r_phase == PH_WAIT) begin
                    n_elapsed = tick_sum;
                    if (timed_out) begin
                        n_phase = PH_IDLE;
                    end
                end
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------------
    // Result generation: the run of results caused by the incoming item
    // ------------------------------------------------------------------------
    always_comb begin
        for (int i = 0; i < RUN_DEPTH; i++) begin
            n_run[i] = '{kind: KIND_TX, value: 8'd0, slot: 3'd0, status: STAT_OK};
        end
        n_cnt = '0;
        case (t_mode'(i_mode))
            MODE_START: begin
                for (int i = 0; i < RUN_DEPTH; i++) begin
                    n_run[i].value = frame[i];
                end
                n_cnt = RUN_W'(RUN_DEPTH);
            end
            MODE_BYTE: begin
                case (r_phase)
                    PH_WAIT: begin
                        if (!i_card_byte[7]) begin
                            if (r_left == '0) begin
                                if (!r_busy_req) begin
                                    n_run[0].kind = KIND_STATUS;
                                    n_cnt         = RUN_W'(1);
                                end
                            end else begin
                                n_run[0].kind  = KIND_RESP;
                                n_run[0].value = i_card_byte;
                                n_cnt          = RUN_W'(1);
                            end
                        end
                    end
                    PH_CAPTURE: begin
                        n_run[0].kind  = KIND_RESP;
                        n_run[0].value = i_card_byte;
                        n_run[0].slot  = r_slot;
                        n_cnt          = RUN_W'(1);
                    end
                    PH_TRAIL: begin
                        // drop the trailing byte; close unless busy wait follows
                        if (!r_busy_req) begin
                            n_run[0].kind = KIND_STATUS;
                            n_cnt         = RUN_W'(1);
                        end
                    end
                    PH_BUSY: begin
                        if (i_card_byte == BYTE_IDLE) begin
                            n_run[0].value = BYTE_IDLE;
                            n_run[1].kind  = KIND_STATUS;
                            n_cnt          = RUN_W'(2);
                        end
                    end
                    default: ;
                endcase
            end
            MODE_TICK: begin
                if ((r_phase == PH_WAIT) && timed_out) begin
                    n_run[0].kind   = KIND_STATUS;
                    n_run[0].status = STAT_TIMEOUT;
                    n_cnt           = RUN_W'(1);
                end
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout  <= '1;
            r_phase    <= PH_IDLE;
            r_elapsed  <= '0;
            r_left     <= '0;
            r_slot     <= '0;
            r_busy_req <= 1'b0;
            r_cnt      <= '0;
            r_rd       <= '0;
        end else begin
            if (i_cfg_we) begin
                r_timeout <= i_cfg_wdata;
            end
            if (in_xfer) begin
                // advance the engine and load the new run
                r_phase    <= n_phase;
                r_elapsed  <= n_elapsed;
                r_left     <= n_left;
                r_slot     <= n_slot;
                r_busy_req <= n_busy_req;
                r_cnt      <= n_cnt;
                r_rd       <= '0;
            end else if (out_xfer) begin
                if (run_last) begin
                    r_cnt <= '0;
                    r_rd  <= '0;
                end else begin
                    r_rd <= r_rd + RUN_W'(1);
                end
            end
        end
    end

    // Result payload: no reset needed
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            for (int i = 0; i < RUN_DEPTH; i++) begin
                r_run[i] <= n_run[i];
            end
        end
    end

    // ------------------------------------------------------------------------
    // Output fields
    // ------------------------------------------------------------------------
    t_result cur;
    assign cur                 = r_run[r_rd];
    assign o_result_kind       = cur.kind;
    assign o_byte_value        = cur.value;
    assign o_response_slot     = cur.slot;
    assign o_completion_status = cur.status;
    assign o_last_of_run       = run_last;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    // shown entry always lies inside the loaded run
    a_rd_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_rd < r_cnt))
        else $error("read pointer outside result run");

    // a start transfer loads a full six-result frame
    a_start_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && (i_mode == MODE_START)) |=>
            (o_out_valid && (r_cnt == RUN_W'(RUN_DEPTH)) && (r_phase == PH_WAIT)))
        else $error("start item did not load a command frame");

    // capture phase always has a byte left to take
    a_capture_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_CAPTURE) |-> (r_left != '0))
        else $error("capture phase with no bytes left");

    // input side only opens once the pending run has been taken
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("input taken while results still pending");

endmodule
